### design/spbr_pkg.sv
// Shared types, constants and reload arithmetic for the servo slew and brake unit.
package spbr_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned DivSteps  = 8;
  localparam int unsigned HighBase  = 65075;
  localparam int unsigned LowBase   = 47566;
  localparam int unsigned ScaleNum  = 2619;

  typedef enum logic [1:0] {
    CMD_PULSE    = 2'd0,
    CMD_LOCK_END = 2'd1,
    CMD_STEER    = 2'd2,
    CMD_BRAKE    = 2'd3
  } spbr_cmd_e;

  typedef enum logic [2:0] {
    REG_BRAKE_ON   = 3'd0,
    REG_BRAKE_OFF  = 3'd1,
    REG_FAST_COUNT = 3'd2,
    REG_SLOW_COUNT = 3'd3,
    REG_MAX_RISE   = 3'd4,
    REG_WINDOW     = 3'd5,
    REG_MIN_SPEED  = 3'd6,
    REG_MAX_SPEED  = 3'd7
  } spbr_reg_e;

  typedef struct packed {
    spbr_cmd_e  command;
    logic [7:0] target_angle;
    logic       brake_enable;
  } spbr_in_t;

  typedef struct packed {
    logic        steer_level;
    logic [15:0] steer_reload;
    logic        brake_level;
    logic [15:0] brake_reload;
    logic [7:0]  steer_position;
    logic [7:0]  brake_position;
    logic [4:0]  speed_level;
    logic        pulse_counted;
  } spbr_out_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [5:0] divisor;
  } spbr_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } spbr_div_rsp_t;

  // high phase: floor((65075*256 - pos*2619) / 256)
  function automatic logic [15:0] reload_high(logic [7:0] pos);
    logic [23:0] prod;
    logic [23:0] diff;
    prod = 24'(pos) * 24'(ScaleNum);
    diff = 24'(HighBase * 256) - prod;
    return diff[23:8];
  endfunction

  // low phase: floor((47566*256 + pos*2619) / 256)
  function automatic logic [15:0] reload_low(logic [7:0] pos);
    logic [23:0] prod;
    logic [23:0] sum;
    prod = 24'(pos) * 24'(ScaleNum);
    sum  = 24'(LowBase * 256) + prod;
    return sum[23:8];
  endfunction

endpackage

### design/spbr_slew_div.sv
// Restoring serial divider, one quotient bit per cycle, for the steering slew step.
module spbr_slew_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spbr_pkg::spbr_div_req_t req_i,
  output spbr_pkg::spbr_div_rsp_t rsp_o
);
  import spbr_pkg::*;

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [5:0] rem_q, rem_d;
  logic [5:0] dsr_q, dsr_d;
  logic [7:0] quo_q, quo_d;
  logic [6:0] trial;

  assign trial = {rem_q, quo_q[7]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 6'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = trial[5:0];
        quo_d = {quo_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q == 3'(DivSteps - 1) |=> done_q && !busy_q)
    else $error("divider missed its final step");

endmodule

### design/servo_pwm_slew_speed_brake_unit.sv
// Top level: event sequencer, servo state, speed window and brake hysteresis.
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o  | one event (spbr_in_t)
//  out     | output    | out_valid_o/out_ready_i  | one result (spbr_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o  | register index and data
//
//  An event is accepted, executed and loaded into the output; a steering low
//  phase whose target differs from the position first waits while the slew
//  step runs through the serial divider, one quotient bit per cycle for 8 bits.
//  Reset sets the state and configuration registers to power-on values; no clearing pass.
//  The output register holds its beat while out_ready_i is low; a finished
//  event then waits in the done state and in_ready_o stays low until it moves.
//  The configuration port is always ready.
module servo_pwm_slew_speed_brake_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spbr_pkg::spbr_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spbr_pkg::spbr_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import spbr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } spbr_state_e;

  spbr_state_e state_q, state_d;

  // latched event
  spbr_cmd_e  cmd_q;
  logic [7:0] target_q;
  logic       enable_q;

  // configuration registers
  logic [7:0] brake_on_q, brake_off_q, fast_count_q, slow_count_q, max_rise_q;
  logic [5:0] window_q;
  logic [4:0] min_speed_q, max_speed_q;

  // servo and speed state
  logic                 lockout_q, lockout_d;
  logic [CountBits-1:0] pulse_q, pulse_d;
  logic [CountBits-1:0] prev_q, prev_d;
  logic [4:0]           speed_q, speed_d;
  logic [7:0]           steer_pos_q, steer_pos_d;
  logic [7:0]           brake_pos_q, brake_pos_d;
  logic                 steer_ph_q, steer_ph_d;
  logic                 brake_ph_q, brake_ph_d;
  logic [5:0]           period_q, period_d;
  logic [15:0]          steer_rl_q, steer_rl_d;
  logic [15:0]          brake_rl_q, brake_rl_d;
  logic                 counted_q, counted_d;
  logic                 slew_up_q, slew_up_d;

  logic                 out_valid_q, out_valid_d;
  spbr_out_t            out_q, out_d;
  logic                 out_load;

  spbr_div_req_t        div_req;
  spbr_div_rsp_t        div_rsp;

  // window arithmetic
  logic [CountBits-1:0] rise, cnt_lim;
  logic [4:0]           spd_cap, spd_win;
  logic [5:0]           pc_inc;
  logic [5:0]           slew_k;
  logic [7:0]           slew_t;
  logic [7:0]           slew_step;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // limit the rise of the window count, then clamp it into the speed range
  assign rise    = pulse_q - prev_q;
  assign cnt_lim = (pulse_q > prev_q && rise > CountBits'(max_rise_q))
                   ? prev_q + CountBits'(max_rise_q) : pulse_q;
  assign spd_cap = (cnt_lim > CountBits'(max_speed_q)) ? max_speed_q : cnt_lim[4:0];
  assign spd_win = (spd_cap < min_speed_q) ? min_speed_q : spd_cap;
  assign pc_inc  = period_q + 6'd1;

  // slew divisor (32 - speed) * 1.5, always 1..48
  assign slew_k    = 6'd32 - {1'b0, speed_q};
  assign slew_t    = {2'b00, slew_k} + {1'b0, slew_k, 1'b0};
  assign slew_step = div_rsp.quotient + 8'd2;

  spbr_slew_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    lockout_d   = lockout_q;
    pulse_d     = pulse_q;
    prev_d      = prev_q;
    speed_d     = speed_q;
    steer_pos_d = steer_pos_q;
    brake_pos_d = brake_pos_q;
    steer_ph_d  = steer_ph_q;
    brake_ph_d  = brake_ph_q;
    period_d    = period_q;
    steer_rl_d  = steer_rl_q;
    brake_rl_d  = brake_rl_q;
    counted_d   = counted_q;
    slew_up_d   = slew_up_q;
    out_load    = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = (target_q > steer_pos_q) ? target_q - steer_pos_q
                                                : steer_pos_q - target_q;
    div_req.divisor  = slew_t[6:1];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        counted_d = 1'b0;
        state_d   = S_DONE;
        case (cmd_q)
          CMD_PULSE: begin
            if (!lockout_q) begin
              lockout_d = 1'b1;
              counted_d = 1'b1;
              if (pulse_q != '1) begin
                pulse_d = pulse_q + CountBits'(1);
              end
            end
          end
          CMD_LOCK_END: begin
            lockout_d = 1'b0;
          end
          CMD_STEER: begin
            if (!steer_ph_q) begin
              steer_rl_d = reload_high(steer_pos_q);
              steer_ph_d = 1'b1;
            end else begin
              // reload uses the position from before the slew
              steer_rl_d = reload_low(steer_pos_q);
              steer_ph_d = 1'b0;
              if (target_q != steer_pos_q) begin
                div_req.start = 1'b1;
                slew_up_d     = (target_q > steer_pos_q);
                state_d       = S_DIV;
              end
            end
          end
          CMD_BRAKE: begin
            if (!brake_ph_q) begin
              brake_rl_d = reload_high(brake_pos_q);
              brake_ph_d = 1'b1;
            end else begin
              brake_rl_d = reload_low(brake_pos_q);
              brake_ph_d = 1'b0;
              period_d   = pc_inc;
              if (pc_inc >= window_q) begin
                // close the speed window
                period_d = '0;
                prev_d   = cnt_lim;
                speed_d  = spd_win;
                pulse_d  = '0;
                if (!enable_q) begin
                  brake_pos_d = brake_off_q;
                end else if (cnt_lim >= CountBits'(fast_count_q)) begin
                  brake_pos_d = brake_on_q;
                end else if (cnt_lim <= CountBits'(slow_count_q)) begin
                  brake_pos_d = brake_off_q;
                end
              end
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          steer_pos_d = slew_up_q ? steer_pos_q + slew_step : steer_pos_q - slew_step;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d.steer_level    = steer_ph_q;
    out_d.steer_reload   = steer_rl_q;
    out_d.brake_level    = brake_ph_q;
    out_d.brake_reload   = brake_rl_q;
    out_d.steer_position = steer_pos_q;
    out_d.brake_position = brake_pos_q;
    out_d.speed_level    = speed_q;
    out_d.pulse_counted  = counted_q;
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lockout_q   <= 1'b0;
      pulse_q     <= '0;
      prev_q      <= '0;
      speed_q     <= 5'd6;
      steer_pos_q <= 8'd90;
      brake_pos_q <= 8'd90;
      steer_ph_q  <= 1'b0;
      brake_ph_q  <= 1'b0;
      period_q    <= '0;
      steer_rl_q  <= '0;
      brake_rl_q  <= '0;
      counted_q   <= 1'b0;
      slew_up_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lockout_q   <= lockout_d;
      pulse_q     <= pulse_d;
      prev_q      <= prev_d;
      speed_q     <= speed_d;
      steer_pos_q <= steer_pos_d;
      brake_pos_q <= brake_pos_d;
      steer_ph_q  <= steer_ph_d;
      brake_ph_q  <= brake_ph_d;
      period_q    <= period_d;
      steer_rl_q  <= steer_rl_d;
      brake_rl_q  <= brake_rl_d;
      counted_q   <= counted_d;
      slew_up_q   <= slew_up_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brake_on_q   <= 8'd93;
      brake_off_q  <= 8'd70;
      fast_count_q <= 8'd15;
      slow_count_q <= 8'd8;
      max_rise_q   <= 8'd50;
      window_q     <= 6'd20;
      min_speed_q  <= 5'd6;
      max_speed_q  <= 5'd25;
    end else if (cfg_valid_i) begin
      case (spbr_reg_e'(cfg_index_i))
        REG_BRAKE_ON:   brake_on_q   <= cfg_data_i;
        REG_BRAKE_OFF:  brake_off_q  <= cfg_data_i;
        REG_FAST_COUNT: fast_count_q <= cfg_data_i;
        REG_SLOW_COUNT: slow_count_q <= cfg_data_i;
        REG_MAX_RISE:   max_rise_q   <= cfg_data_i;
        REG_WINDOW:     window_q     <= cfg_data_i[5:0];
        REG_MIN_SPEED:  min_speed_q  <= cfg_data_i[4:0];
        REG_MAX_SPEED:  max_speed_q  <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // event and output payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= in_data_i.command;
      target_q <= in_data_i.target_angle;
      enable_q <= in_data_i.brake_enable;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  a_div_only_steer_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> cmd_q == CMD_STEER && steer_ph_q && state_q == S_EXEC)
    else $error("slew divide started outside a steering low phase");
  a_div_enters_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> state_q == S_DIV)
    else $error("sequencer did not wait for the divider");
  a_div_done_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && div_rsp.done |=> state_q == S_DONE)
    else $error("divider result dropped");
  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output beat raised outside the done state");

endmodule

### verif/testbench.sv
// Self-checking testbench for the servo slew, speed window and brake unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spbr_pkg::*;

  // Hold the receiver off once it has taken this many results, for this many cycles.
  localparam int unsigned HoldAtResult = 400;
  localparam int unsigned HoldCycles   = 300;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic       in_ready;
  spbr_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  spbr_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  servo_pwm_slew_speed_brake_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioural model of the unit: register copy and servo/speed state.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] on_angle;
    logic [7:0] off_angle;
    logic [7:0] fast;
    logic [7:0] slow;
    logic [7:0] rise;
    logic [5:0] window;
    logic [4:0] min_spd;
    logic [4:0] max_spd;
  } brake_regs_t;

  brake_regs_t brake_cfg = '{on_angle: 8'd93, off_angle: 8'd70, fast: 8'd15, slow: 8'd8,
                             rise: 8'd50, window: 6'd20, min_spd: 5'd6, max_spd: 5'd25};

  logic        lockout       = 1'b0;
  logic [15:0] wheel_count   = '0;
  logic [15:0] last_count    = '0;
  logic [4:0]  speed         = 5'd6;
  logic [7:0]  steer_pos     = 8'd90;
  logic [7:0]  brake_pos     = 8'd90;
  logic        steer_high    = 1'b0;
  logic        brake_high    = 1'b0;
  logic [5:0]  brake_periods = '0;
  logic [15:0] steer_reload  = '0;
  logic [15:0] brake_reload  = '0;

  // run statistics
  int unsigned events_taken   = 0;
  int unsigned results_seen   = 0;
  int unsigned pulses_counted = 0;
  int unsigned windows_closed = 0;
  int unsigned slew_steps     = 0;
  int unsigned settings_used  = 0;
  int unsigned failures       = 0;

  spbr_in_t  events_to_send[$];
  spbr_out_t predicted_results[$];

  function automatic logic [15:0] high_reload(logic [7:0] pos);
    return 16'((HighBase * 256 - 32'(pos) * ScaleNum) >> 8);
  endfunction

  function automatic logic [15:0] low_reload(logic [7:0] pos);
    return 16'((LowBase * 256 + 32'(pos) * ScaleNum) >> 8);
  endfunction

  // Toggle the steering phase; on the low phase slew towards the target,
  // using the reload of the position from before the slew.
  function automatic void steer_overflow(logic [7:0] target);
    int unsigned step_div;
    int unsigned diff;
    if (!steer_high) begin
      steer_reload = high_reload(steer_pos);
      steer_high   = 1'b1;
      return;
    end
    steer_reload = low_reload(steer_pos);
    steer_high   = 1'b0;
    step_div     = ((32 - 32'(speed)) * 3) >> 1;
    if (target > steer_pos) begin
      diff      = 32'(target) - 32'(steer_pos);
      steer_pos = 8'(steer_pos + diff / step_div + 2);
      slew_steps++;
    end else if (target < steer_pos) begin
      diff      = 32'(steer_pos) - 32'(target);
      steer_pos = 8'(steer_pos - (diff / step_div + 2));
      slew_steps++;
    end
  endfunction

  // Limit the rise, clamp the speed (max first, so min wins on a cross) and
  // pick the brake angle with hysteresis.
  function automatic void close_window(logic enable);
    int unsigned cnt;
    int unsigned lvl;
    cnt = 32'(wheel_count);
    if (cnt > 32'(last_count) && cnt - 32'(last_count) > 32'(brake_cfg.rise))
      cnt = (32'(last_count) + 32'(brake_cfg.rise)) & 32'hFFFF;
    last_count = 16'(cnt);
    lvl = cnt;
    if (lvl > 32'(brake_cfg.max_spd)) lvl = 32'(brake_cfg.max_spd);
    if (lvl < 32'(brake_cfg.min_spd)) lvl = 32'(brake_cfg.min_spd);
    speed = 5'(lvl);
    if (!enable) begin
      brake_pos = brake_cfg.off_angle;
    end else if (cnt >= 32'(brake_cfg.fast)) begin
      brake_pos = brake_cfg.on_angle;
    end else if (cnt <= 32'(brake_cfg.slow)) begin
      brake_pos = brake_cfg.off_angle;
    end
    wheel_count = '0;
    windows_closed++;
  endfunction

  function automatic void brake_overflow(logic enable);
    if (!brake_high) begin
      brake_reload = high_reload(brake_pos);
      brake_high   = 1'b1;
      return;
    end
    brake_reload  = low_reload(brake_pos);
    brake_high    = 1'b0;
    brake_periods = 6'(brake_periods + 1);
    if (brake_periods >= brake_cfg.window) begin
      brake_periods = '0;
      close_window(enable);
    end
  endfunction

  // Advance the model by one event and return the result it should produce.
  function automatic spbr_out_t apply_event(spbr_in_t ev);
    spbr_out_t res;
    logic      counted;
    counted = 1'b0;
    case (ev.command)
      CMD_PULSE: begin
        if (!lockout) begin
          lockout = 1'b1;
          if (wheel_count != 16'hFFFF) wheel_count++;
          counted = 1'b1;
          pulses_counted++;
        end
      end
      CMD_LOCK_END: lockout = 1'b0;
      CMD_STEER:    steer_overflow(ev.target_angle);
      default:      brake_overflow(ev.brake_enable);
    endcase
    res.steer_level    = steer_high;
    res.steer_reload   = steer_reload;
    res.brake_level    = brake_high;
    res.brake_reload   = brake_reload;
    res.steer_position = steer_pos;
    res.brake_position = brake_pos;
    res.speed_level    = speed;
    res.pulse_counted  = counted;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed events from the pending queue in bursts with idle gaps.
  // ---------------------------------------------------------------------------
  bit          steady     = 1'b0;  // no idling on either side while set
  int unsigned burst_left = 1;
  int unsigned idle_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      // Predict at the accepting edge, so order follows the beats exactly.
      if (in_valid && in_ready) begin
        predicted_results.push_back(apply_event(in_data));
        events_taken++;
      end
      // Hold an offered beat until taken; otherwise load the next one or idle.
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (events_to_send.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= events_to_send.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (steady || $urandom_range(0, 3) == 0) idle_left = 0;
            else idle_left = $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with a rotating stall pattern and check each one.
  // ---------------------------------------------------------------------------
  int unsigned hold_left    = 0;
  int unsigned pattern_left = 0;
  logic [7:0]  stall_mask   = 8'hFF;
  spbr_out_t   want;

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing predicted");
          failures++;
        end else begin
          want = predicted_results.pop_front();
          check_field("steer_level",    32'(want.steer_level),    32'(out_data.steer_level));
          check_field("steer_reload",   32'(want.steer_reload),   32'(out_data.steer_reload));
          check_field("brake_level",    32'(want.brake_level),    32'(out_data.brake_level));
          check_field("brake_reload",   32'(want.brake_reload),   32'(out_data.brake_reload));
          check_field("steer_position", 32'(want.steer_position),
                      32'(out_data.steer_position));
          check_field("brake_position", 32'(want.brake_position),
                      32'(out_data.brake_position));
          check_field("speed_level",    32'(want.speed_level),    32'(out_data.speed_level));
          check_field("pulse_counted",  32'(want.pulse_counted),
                      32'(out_data.pulse_counted));
        end
        results_seen++;
        // Start the long hold-off once; the sender keeps offering meanwhile.
        if (results_seen == HoldAtResult) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        // Swap the stall mask every so often; a quarter of masks never stall.
        if (pattern_left == 0) begin
          stall_mask   = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
          pattern_left = $urandom_range(8, 64);
        end else begin
          pattern_left--;
        end
        out_ready  <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send(spbr_cmd_e cmd, int unsigned target, logic enable);
    spbr_in_t ev;
    ev.command      = cmd;
    ev.target_angle = 8'(target);
    ev.brake_enable = enable;
    events_to_send.push_back(ev);
  endtask

  // Write one register through the configuration port and mirror it in the model.
  task automatic write_reg(spbr_reg_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_BRAKE_ON:   brake_cfg.on_angle  = val;
      REG_BRAKE_OFF:  brake_cfg.off_angle = val;
      REG_FAST_COUNT: brake_cfg.fast      = val;
      REG_SLOW_COUNT: brake_cfg.slow      = val;
      REG_MAX_RISE:   brake_cfg.rise      = val;
      REG_WINDOW:     brake_cfg.window    = val[5:0];
      REG_MIN_SPEED:  brake_cfg.min_spd   = val[4:0];
      default:        brake_cfg.max_spd   = val[4:0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int unsigned on_a, int unsigned off_a, int unsigned fast,
                          int unsigned slow, int unsigned rise, int unsigned win,
                          int unsigned min_s, int unsigned max_s);
    write_reg(REG_BRAKE_ON,   8'(on_a));
    write_reg(REG_BRAKE_OFF,  8'(off_a));
    write_reg(REG_FAST_COUNT, 8'(fast));
    write_reg(REG_SLOW_COUNT, 8'(slow));
    write_reg(REG_MAX_RISE,   8'(rise));
    write_reg(REG_WINDOW,     8'(win));
    write_reg(REG_MIN_SPEED,  8'(min_s));
    write_reg(REG_MAX_SPEED,  8'(max_s));
    settings_used++;
  endtask

  // Wait at the falling edge, when every beat of the cycle has settled, until
  // nothing is queued, offered or still predicted.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (events_to_send.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // Mostly clean wheel beats (pulse then lockout end) mixed with servo overflows,
  // plus some stray pulses and lockout ends as noise. All fields random.
  task automatic queue_traffic(int unsigned n);
    int unsigned queued;
    int unsigned pick;
    queued = 0;
    while (queued < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send(CMD_PULSE, $urandom_range(45, 135), $urandom_range(0, 9) != 0);
        send(CMD_LOCK_END, $urandom_range(45, 135), $urandom_range(0, 9) != 0);
        queued += 2;
      end else begin
        if (pick < 65)      send(CMD_STEER, $urandom_range(45, 135),
                                 1'($urandom_range(0, 1)));
        else if (pick < 90) send(CMD_BRAKE, $urandom_range(45, 135),
                                 $urandom_range(0, 9) != 0);
        else if (pick < 95) send(CMD_PULSE, $urandom_range(45, 135),
                                 1'($urandom_range(0, 1)));
        else                send(CMD_LOCK_END, $urandom_range(45, 135),
                                 1'($urandom_range(0, 1)));
        queued++;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, both steering phases, no slew when on target,
    // slew up and down, lockout handling and a lockout end with none active.
    send(CMD_STEER, 90, 1'b0);
    send(CMD_STEER, 90, 1'b0);
    send(CMD_STEER, 135, 1'b1);
    send(CMD_STEER, 135, 1'b1);
    send(CMD_STEER, 45, 1'b0);
    send(CMD_STEER, 45, 1'b0);
    send(CMD_PULSE, 45, 1'b1);
    send(CMD_PULSE, 135, 1'b1);      // ignored: still locked out
    send(CMD_LOCK_END, 45, 1'b0);
    send(CMD_PULSE, 45, 1'b0);
    send(CMD_LOCK_END, 45, 1'b1);
    send(CMD_LOCK_END, 135, 1'b1);
    send(CMD_BRAKE, 45, 1'b1);
    send(CMD_BRAKE, 45, 1'b1);
    wait_idle();

    // Zero-length window: every brake low phase closes one; then forced release.
    write_reg(REG_WINDOW, 8'd0);
    send(CMD_PULSE, 90, 1'b1);
    send(CMD_LOCK_END, 90, 1'b1);
    send(CMD_BRAKE, 90, 1'b1);
    send(CMD_BRAKE, 90, 1'b1);
    send(CMD_BRAKE, 90, 1'b0);
    send(CMD_BRAKE, 90, 1'b0);
    wait_idle();

    // Shrink the window below the running period count: the next low phase closes.
    write_reg(REG_WINDOW, 8'd6);
    repeat (6) send(CMD_BRAKE, 100, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW, 8'd2);
    send(CMD_BRAKE, 100, 1'b1);
    send(CMD_BRAKE, 100, 1'b1);
    wait_idle();

    // Random traffic under several settings, extremes among them.
    set_regs(93, 70, 12, 6, 50, 3, 6, 25);
    queue_traffic(190);
    set_regs(180, 0, 255, 0, 255, 1, 1, 31);
    queue_traffic(180);
    set_regs(0, 180, 0, 255, 0, 2, 31, 31);
    queue_traffic(180);
    set_regs(255, 200, 10, 5, 4, 4, 20, 10);   // angles above 180, clamps crossed
    queue_traffic(190);
    set_regs(120, 45, 8, 3, 20, 63, 1, 31);
    queue_traffic(120);
    set_regs($urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(4, 20),
             $urandom_range(0, 6), $urandom_range(1, 60), $urandom_range(2, 8),
             $urandom_range(1, 12), $urandom_range(8, 31));
    // Last stretch with no idling on either side, so beats follow back to back.
    steady = 1'b1;
    queue_traffic(240);

    // Allow for a late stray beat after the last expected one.
    repeat (20) @(posedge clk_i);

    $display("Run: %0d events over %0d register settings, %0d results checked.",
             events_taken, settings_used, results_seen);
    $display("Behaviour: %0d wheel pulses counted, %0d speed windows, %0d slew steps.",
             pulses_counted, windows_closed, slew_steps);
    if (failures == 0 && predicted_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
